// File: hdl/keyboard_scan_code_translator_assert.svh
// Assertion macros shared by the keyboard scan code translator RTL.
`ifndef KEYBOARD_SCAN_CODE_TRANSLATOR_ASSERT_SVH
`define KEYBOARD_SCAN_CODE_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while reset is asserted.
`define KBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while reset is asserted.
`define KBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/kbd_pkg.sv
// Package with types, key numbers and character tables for the scan code translator.
`timescale 1ns / 1ps

package kbd_pkg;

  localparam logic [7:0] HALT_CODE   = 8'h54;
  localparam logic [7:0] RELEASE_BIT = 8'h80;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] LOWER_A     = 8'h61;
  localparam logic [7:0] LOWER_Z     = 8'h7A;

  localparam logic [6:0] KEY_NONE   = 7'd0;
  localparam logic [6:0] KEY_CTRL   = 7'd29;
  localparam logic [6:0] KEY_LSHIFT = 7'd42;
  localparam logic [6:0] KEY_RSHIFT = 7'd54;
  localparam logic [6:0] KEY_ALT    = 7'd56;
  localparam logic [6:0] KEY_CAPS   = 7'd58;
  localparam logic [6:0] KEY_F1     = 7'd59;
  localparam logic [6:0] KEY_F10    = 7'd68;
  localparam logic [6:0] KEY_NUM    = 7'd69;
  localparam logic [6:0] KEY_SCROLL = 7'd70;
  localparam logic [6:0] KEY_COUNT  = 7'd84;

  localparam int unsigned DEBUG_W = 11;

  typedef struct packed {
    logic [7:0]         prev_code;
    logic               shift_held;
    logic               alt_held;
    logic               ctrl_held;
    logic               caps_on;
    logic               numlock_on;
    logic               output_stop;
    logic [DEBUG_W-1:0] debug_mask;
  } kbd_state_t;

  typedef struct packed {
    logic               char_valid;
    logic [7:0]         char_code;
    logic               halt_request;
    logic [DEBUG_W-1:0] debug_bits;
  } kbd_result_t;

  function automatic logic is_char_key(input logic [6:0] k);
    logic ok;
    ok = 1'b1;
    if (k == KEY_NONE || k >= KEY_COUNT) ok = 1'b0;
    if (k == KEY_CTRL || k == KEY_LSHIFT || k == KEY_RSHIFT || k == KEY_ALT) ok = 1'b0;
    if (k >= KEY_CAPS && k <= KEY_SCROLL) ok = 1'b0;
    return ok;
  endfunction

  // Keypad keys give the same digits with or without shift.
  function automatic logic [7:0] keypad_char(input logic [6:0] k);
    logic [7:0] c;
    case (k)
      7'd71: c = 8'h37;
      7'd72: c = 8'h38;
      7'd73: c = 8'h39;
      7'd74: c = 8'h2D;
      7'd75: c = 8'h34;
      7'd76: c = 8'h35;
      7'd77: c = 8'h36;
      7'd78: c = 8'h2B;
      7'd79: c = 8'h31;
      7'd80: c = 8'h32;
      7'd81: c = 8'h33;
      7'd82: c = 8'h30;
      7'd83: c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] plain_char(input logic [6:0] k);
    logic [7:0] c;
    case (k)
      7'd1:  c = 8'h1B;
      7'd2:  c = 8'h31;
      7'd3:  c = 8'h32;
      7'd4:  c = 8'h33;
      7'd5:  c = 8'h34;
      7'd6:  c = 8'h35;
      7'd7:  c = 8'h36;
      7'd8:  c = 8'h37;
      7'd9:  c = 8'h38;
      7'd10: c = 8'h39;
      7'd11: c = 8'h30;
      7'd12: c = 8'h2D;
      7'd13: c = 8'h3D;
      7'd14: c = 8'h7F;
      7'd15: c = 8'h09;
      7'd16: c = 8'h71;
      7'd17: c = 8'h77;
      7'd18: c = 8'h65;
      7'd19: c = 8'h72;
      7'd20: c = 8'h74;
      7'd21: c = 8'h79;
      7'd22: c = 8'h75;
      7'd23: c = 8'h69;
      7'd24: c = 8'h6F;
      7'd25: c = 8'h70;
      7'd26: c = 8'h5B;
      7'd27: c = 8'h5D;
      7'd28: c = 8'h0D;
      7'd30: c = 8'h61;
      7'd31: c = 8'h73;
      7'd32: c = 8'h64;
      7'd33: c = 8'h66;
      7'd34: c = 8'h67;
      7'd35: c = 8'h68;
      7'd36: c = 8'h6A;
      7'd37: c = 8'h6B;
      7'd38: c = 8'h6C;
      7'd39: c = 8'h3B;
      7'd40: c = 8'h27;
      7'd41: c = 8'h60;
      7'd43: c = 8'h5C;
      7'd44: c = 8'h7A;
      7'd45: c = 8'h78;
      7'd46: c = 8'h63;
      7'd47: c = 8'h76;
      7'd48: c = 8'h62;
      7'd49: c = 8'h6E;
      7'd50: c = 8'h6D;
      7'd51: c = 8'h2C;
      7'd52: c = 8'h2E;
      7'd53: c = 8'h2F;
      7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      default: c = keypad_char(k);
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] k);
    logic [7:0] c;
    case (k)
      7'd1:  c = 8'h1B;
      7'd2:  c = 8'h21;
      7'd3:  c = 8'h40;
      7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;
      7'd6:  c = 8'h25;
      7'd7:  c = 8'h5E;
      7'd8:  c = 8'h26;
      7'd9:  c = 8'h2A;
      7'd10: c = 8'h28;
      7'd11: c = 8'h29;
      7'd12: c = 8'h5F;
      7'd13: c = 8'h2B;
      7'd14: c = 8'h7F;
      7'd15: c = 8'h09;
      7'd16: c = 8'h51;
      7'd17: c = 8'h57;
      7'd18: c = 8'h45;
      7'd19: c = 8'h52;
      7'd20: c = 8'h54;
      7'd21: c = 8'h59;
      7'd22: c = 8'h55;
      7'd23: c = 8'h49;
      7'd24: c = 8'h4F;
      7'd25: c = 8'h50;
      7'd26: c = 8'h7B;
      7'd27: c = 8'h7D;
      7'd28: c = 8'h0D;
      7'd30: c = 8'h41;
      7'd31: c = 8'h53;
      7'd32: c = 8'h44;
      7'd33: c = 8'h46;
      7'd34: c = 8'h47;
      7'd35: c = 8'h48;
      7'd36: c = 8'h4A;
      7'd37: c = 8'h4B;
      7'd38: c = 8'h4C;
      7'd39: c = 8'h3A;
      7'd40: c = 8'h22;
      7'd41: c = 8'h7E;
      7'd43: c = 8'h7C;
      7'd44: c = 8'h5A;
      7'd45: c = 8'h58;
      7'd46: c = 8'h43;
      7'd47: c = 8'h56;
      7'd48: c = 8'h42;
      7'd49: c = 8'h4E;
      7'd50: c = 8'h4D;
      7'd51: c = 8'h3C;
      7'd52: c = 8'h3E;
      7'd53: c = 8'h3F;
      7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      default: c = keypad_char(k);
    endcase
    return c;
  endfunction

  // Control table: keypad keys give zero here.
  function automatic logic [7:0] ctrl_char(input logic [6:0] k);
    logic [7:0] c;
    case (k)
      7'd1:  c = 8'h1B;
      7'd2:  c = 8'h21;
      7'd3:  c = 8'h00;
      7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;
      7'd6:  c = 8'h25;
      7'd7:  c = 8'h1E;
      7'd8:  c = 8'h26;
      7'd9:  c = 8'h2A;
      7'd10: c = 8'h28;
      7'd11: c = 8'h29;
      7'd12: c = 8'h1F;
      7'd13: c = 8'h2B;
      7'd14: c = 8'h1C;
      7'd15: c = 8'h7F;
      7'd16: c = 8'h11;
      7'd17: c = 8'h17;
      7'd18: c = 8'h05;
      7'd19: c = 8'h12;
      7'd20: c = 8'h14;
      7'd21: c = 8'h19;
      7'd22: c = 8'h15;
      7'd23: c = 8'h09;
      7'd24: c = 8'h0F;
      7'd25: c = 8'h10;
      7'd26: c = 8'h1B;
      7'd27: c = 8'h1D;
      7'd28: c = 8'h0D;
      7'd30: c = 8'h01;
      7'd31: c = 8'h13;
      7'd32: c = 8'h04;
      7'd33: c = 8'h06;
      7'd34: c = 8'h07;
      7'd35: c = 8'h08;
      7'd36: c = 8'h0A;
      7'd37: c = 8'h0B;
      7'd38: c = 8'h0C;
      7'd39: c = 8'h3B;
      7'd40: c = 8'h27;
      7'd41: c = 8'h60;
      7'd43: c = 8'h1C;
      7'd44: c = 8'h1A;
      7'd45: c = 8'h18;
      7'd46: c = 8'h03;
      7'd47: c = 8'h16;
      7'd48: c = 8'h02;
      7'd49: c = 8'h0E;
      7'd50: c = 8'h0D;
      7'd51: c = 8'h3C;
      7'd52: c = 8'h3E;
      7'd53: c = 8'h3F;
      7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/kbd_xlate.sv
// Combinational translation of one scan byte against the current keyboard flags.
`timescale 1ns / 1ps

module kbd_xlate (
  input  logic [7:0]          code,
  input  kbd_pkg::kbd_state_t cur,
  output kbd_pkg::kbd_state_t nxt,
  output kbd_pkg::kbd_result_t res
);
  import kbd_pkg::*;

  logic       brk;
  logic [6:0] key;
  logic [3:0] dbg_idx;
  logic [7:0] chr;

  assign brk     = (code & RELEASE_BIT) != 8'h00;
  assign key     = code[6:0];
  assign dbg_idx = 4'(key - KEY_CAPS);

  always_comb begin
    nxt = cur;
    res = '0;
    chr = 8'h00;
    if (code != cur.prev_code) begin
      nxt.prev_code = code;
      if (code == HALT_CODE) begin
        res.halt_request = 1'b1;
      end else begin
        if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
          nxt.shift_held = !brk;
        end else if (key == KEY_ALT) begin
          nxt.alt_held = !brk;
        end else if (key == KEY_CTRL) begin
          nxt.ctrl_held = !brk;
        end else if (key == KEY_CAPS) begin
          if (!brk) nxt.caps_on = !cur.caps_on;
        end else if (key == KEY_NUM) begin
          if (!brk) nxt.numlock_on = !cur.numlock_on;
        end else if (key == KEY_SCROLL) begin
          if (!brk) nxt.output_stop = !cur.output_stop;
        end else if (key >= KEY_F1 && key <= KEY_F10) begin
          if (brk) nxt.debug_mask = cur.debug_mask ^ (DEBUG_W'(1) << dbg_idx);
        end

        if (!nxt.output_stop && !brk && is_char_key(key)) begin
          if (nxt.shift_held) begin
            chr = shift_char(key);
          end else if (nxt.ctrl_held) begin
            chr = ctrl_char(key);
          end else begin
            chr = plain_char(key);
          end
          if (nxt.caps_on && chr >= LOWER_A && chr <= LOWER_Z) begin
            chr = chr - CASE_OFFSET;
          end
          res.char_valid = 1'b1;
          res.char_code  = chr;
        end
      end
    end
    res.debug_bits = nxt.debug_mask;
  end

endmodule

// File: hdl/keyboard_scan_code_translator.sv
// Top level of the keyboard scan code translator: input stage, flag state and result register.
`timescale 1ns / 1ps

// The block turns raw set 1 scan bytes into characters, one result per byte.
// Input channel: in_valid, in_scan_code, in_stall. A transaction happens at a
// rising edge where in_valid is high and in_stall is low.
// Output channel: out_valid, out_char_valid, out_char_code, out_halt_request,
// out_debug_bits, out_stall, with the same transaction rule.
// Every input transaction produces exactly one output transaction, in order.
// A byte equal to the one before is swallowed: its result carries no
// character and no halt request, only the current debug mask.
// The byte is captured in the input register, then the translation and flag
// update run in combinational table lookup logic and land in the result
// register. Throughput is one transaction per cycle while out_stall is low,
// set by the single lookup stage; the flag registers update as a byte leaves
// the input register, so the next byte always sees the flags of the one before.
// While out_stall holds the result register, one more byte can still be taken
// into the input register; after that in_stall rises until the result drains.
// Synchronous reset (rst_n low) empties both registers and clears all held
// and lock flags, the debug mask and the remembered previous byte.
module keyboard_scan_code_translator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_scan_code,
  output logic        in_stall,
  output logic        out_valid,
  output logic        out_char_valid,
  output logic [7:0]  out_char_code,
  output logic        out_halt_request,
  output logic [10:0] out_debug_bits,
  input  logic        out_stall
);
  import kbd_pkg::*;

  `include "keyboard_scan_code_translator_assert.svh"

  logic        in_valid_r;
  logic [7:0]  in_code_r;
  logic        out_valid_r;
  kbd_result_t out_res_r;
  kbd_state_t  state_r;
  kbd_state_t  state_nxt;
  kbd_result_t res_nxt;
  logic        advance;

  // The translate stage moves whenever the result register is empty or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  kbd_xlate u_xlate (
    .code (in_code_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (advance) out_valid_r <= in_valid_r;
      if (advance && in_valid_r) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_code_r <= in_scan_code;
    if (advance && in_valid_r) out_res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_char_valid   = out_res_r.char_valid;
  assign out_char_code    = out_res_r.char_code;
  assign out_halt_request = out_res_r.halt_request;
  assign out_debug_bits   = out_res_r.debug_bits;

  // A held byte in the input register must not be lost or altered while the output stalls.
  `KBD_ASSERT_NEXT(a_hold_input, in_valid_r && !advance, in_valid_r && $stable(in_code_r), "input stage lost a stalled byte")

  // A repeated byte must leave every flag untouched.
  `KBD_ASSERT_NEXT(a_repeat_no_change, advance && in_valid_r && in_code_r == state_r.prev_code, $stable(state_r), "repeated byte changed keyboard state")

  // A halt request never comes with a character.
  `KBD_ASSERT_NOW(a_halt_excl, out_valid_r && out_res_r.halt_request, !out_res_r.char_valid, "halt request carried a character")

  // Without a character the code field reads zero.
  `KBD_ASSERT_NOW(a_code_zero, out_valid_r && !out_res_r.char_valid, out_res_r.char_code == 8'h00, "character code not zero without a character")

  // No function key maps to debug bit zero.
  `KBD_ASSERT_NOW(a_dbg_bit0, 1'b1, !state_r.debug_mask[0], "debug bit zero was toggled")

endmodule
